/* hdl/blpc_pkg.sv */
// shared types, constants and duty table for the button level pwm controller
`timescale 1ns / 1ps
`default_nettype none

package blpc_pkg;

  // field widths
  localparam int unsigned COUNT_W = 8;
  localparam int unsigned UNIT_W  = 7;
  localparam int unsigned ELAP_W  = 10;
  localparam int unsigned DUTY_W  = 7;
  localparam int unsigned LEVEL_W = 3;
  localparam int unsigned CFG_IDX_W  = 3;
  localparam int unsigned CFG_DATA_W = 10;
  localparam int unsigned IN_TDATA_W  = 8;
  localparam int unsigned OUT_TDATA_W = 16;

  // level count default and event queue depth
  localparam int unsigned NUM_LEVELS_DEF = 7;
  localparam int unsigned QUEUE_DEPTH    = 2;

  // ramp duty reset value and elapsed unit limit
  localparam logic [DUTY_W-1:0] RAMP_DUTY_RST = 7'd100;
  localparam logic [ELAP_W-1:0] ELAP_MAX      = 10'd1023;

  // configuration register indexes
  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_DEBOUNCE   = 3'd0,
    CFG_LONG_PRESS = 3'd1,
    CFG_TICKS_UNIT = 3'd2,
    CFG_TIMEOUT    = 3'd3,
    CFG_RAMP_FLOOR = 3'd4,
    CFG_RAMP_START = 3'd5,
    CFG_RAMP_STEP  = 3'd6
  } cfg_index_t;

  // press event codes
  typedef enum logic [1:0] {
    EV_NONE  = 2'd0,
    EV_SHORT = 2'd1,
    EV_LONG  = 2'd2
  } press_event_t;

  // one qualified tick from front to back
  typedef struct packed {
    press_event_t ev;
    logic         idle;   // press counter is zero after this tick
  } tick_evt_t;

  // settings used by the back part
  typedef struct packed {
    logic [UNIT_W-1:0] ticks_per_unit;
    logic [ELAP_W-1:0] timeout_units;
    logic [DUTY_W-1:0] ramp_floor;
    logic [DUTY_W-1:0] ramp_start;
    logic [3:0]        ramp_step;
  } back_cfg_t;

  // fixed duty of the levels above one
  function automatic logic [DUTY_W-1:0] fixed_duty(input logic [LEVEL_W-1:0] lvl);
    logic [DUTY_W-1:0] d;
    case (lvl)
      3'd2:    d = 7'd81;
      3'd3:    d = 7'd85;
      3'd4:    d = 7'd90;
      3'd5:    d = 7'd93;
      3'd6:    d = 7'd97;
      3'd7:    d = 7'd97;
      default: d = '0;
    endcase
    return d;
  endfunction

endpackage

`default_nettype wire

/* hdl/blpc_front.sv */
// press qualifier: counts held ticks and classifies short and long presses
`timescale 1ns / 1ps
`default_nettype none

module blpc_front
  import blpc_pkg::*;
(
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               tick,          // word accepted this cycle
  input  wire logic               key_pressed,
  input  wire logic [COUNT_W-1:0] debounce_ticks,
  input  wire logic [COUNT_W-1:0] long_press_ticks,
  output tick_evt_t               evt
);

  logic [COUNT_W-1:0] press_count, press_count_next;
  logic               long_seen, long_seen_next;
  logic [COUNT_W:0]   held_sum;

  // qualifier update for one tick
  always_comb begin
    press_count_next = press_count;
    long_seen_next   = long_seen;
    evt.ev           = EV_NONE;
    held_sum         = {1'b0, press_count} + {{COUNT_W{1'b0}}, 1'b1};
    if (key_pressed) begin
      if (held_sum >= {1'b0, long_press_ticks}) begin
        press_count_next = long_press_ticks;
        if (!long_seen) begin
          long_seen_next = 1'b1;
          evt.ev         = EV_LONG;
        end
      end else begin
        press_count_next = held_sum[COUNT_W-1:0];
      end
    end else begin
      press_count_next = '0;
      if (press_count >= long_press_ticks) begin
        long_seen_next = 1'b0;
      end else if (press_count >= debounce_ticks) begin
        evt.ev = EV_SHORT;
      end
    end
    evt.idle = (press_count_next == '0);
  end

  // qualifier state
  always_ff @(posedge clk) begin
    if (rst) begin
      press_count <= '0;
      long_seen   <= 1'b0;
    end else if (tick) begin
      press_count <= press_count_next;
      long_seen   <= long_seen_next;
    end
  end

endmodule

`default_nettype wire

/* hdl/blpc_queue.sv */
// short event queue between the qualifier and the level logic
`timescale 1ns / 1ps
`default_nettype none

module blpc_queue
  import blpc_pkg::*;
(
  input  wire logic      clk,
  input  wire logic      rst,
  input  wire logic      push,
  input  wire tick_evt_t push_evt,
  output logic           full,
  input  wire logic      pop,
  output logic           avail,
  output tick_evt_t      pop_evt
);

  localparam int unsigned PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int unsigned CNT_W = $clog2(QUEUE_DEPTH + 1);

  tick_evt_t        slots [QUEUE_DEPTH];
  logic [PTR_W-1:0] wr_ptr, rd_ptr;
  logic [CNT_W-1:0] count;

  assign full    = (count == CNT_W'(QUEUE_DEPTH));
  assign avail   = (count != '0);
  assign pop_evt = slots[rd_ptr];

  // storage
  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= push_evt;
    end
  end

  // pointers and fill count
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule

`default_nettype wire

/* hdl/blpc_back.sv */
// level, ramp and timeout logic with the output word register
`timescale 1ns / 1ps
`default_nettype none

module blpc_back
  import blpc_pkg::*;
#(
  parameter int unsigned NUM_LEVELS = NUM_LEVELS_DEF
) (
  input  wire logic                   clk,
  input  wire logic                   rst,
  input  wire back_cfg_t              cfg,
  input  wire logic                   avail,
  input  wire tick_evt_t              evt,
  output logic                        pop,
  output logic                        m_tvalid,
  input  wire logic                   m_tready,
  output logic [OUT_TDATA_W-1:0]      m_tdata
);

  logic [LEVEL_W-1:0] current_level, current_level_next;
  logic [DUTY_W-1:0]  ramp_duty, ramp_duty_next;
  logic [UNIT_W-1:0]  unit_tick_count, unit_tick_count_next;
  logic [ELAP_W-1:0]  elapsed_units, elapsed_units_next;
  logic [UNIT_W:0]    unit_sum;
  logic [LEVEL_W:0]   level_sum;
  logic [DUTY_W-1:0]  duty;
  logic               sleep;
  logic [OUT_TDATA_W-1:0] word_next;

  assign pop = avail && (!m_tvalid || m_tready);

  // one tick of level logic
  always_comb begin
    current_level_next   = current_level;
    ramp_duty_next       = ramp_duty;
    unit_tick_count_next = unit_tick_count;
    elapsed_units_next   = elapsed_units;
    unit_sum  = {1'b0, unit_tick_count} + {{UNIT_W{1'b0}}, 1'b1};
    level_sum = {1'b0, current_level} + {{LEVEL_W{1'b0}}, 1'b1};
    duty      = '0;
    sleep     = 1'b0;

    // timeout counting while on
    if (current_level != '0) begin
      if (unit_sum >= {1'b0, cfg.ticks_per_unit}) begin
        unit_tick_count_next = '0;
        if (elapsed_units != ELAP_MAX) begin
          elapsed_units_next = elapsed_units + 1'b1;
        end
      end else begin
        unit_tick_count_next = unit_sum[UNIT_W-1:0];
      end
    end

    // level change
    case (evt.ev)
      EV_SHORT: begin
        if (level_sum >= (LEVEL_W+1)'(NUM_LEVELS)) begin
          current_level_next = '0;
          elapsed_units_next = '0;
        end else begin
          current_level_next = level_sum[LEVEL_W-1:0];
        end
        if (current_level_next == LEVEL_W'(1)) begin
          ramp_duty_next = cfg.ramp_start;
        end
      end
      EV_LONG: current_level_next = '0;
      default: ;
    endcase

    // duty selection
    if (current_level_next == '0) begin
      sleep = evt.idle;
    end else if (current_level_next == LEVEL_W'(1)) begin
      if (ramp_duty_next > cfg.ramp_floor) begin
        ramp_duty_next = (ramp_duty_next >= {3'b000, cfg.ramp_step}) ?
                         ramp_duty_next - {3'b000, cfg.ramp_step} : '0;
        duty = ramp_duty_next;
      end else begin
        duty = cfg.ramp_floor;
      end
    end else begin
      duty = fixed_duty(current_level_next);
    end

    // timeout and sleep
    if (elapsed_units_next >= cfg.timeout_units) begin
      sleep = 1'b1;
    end
    if (sleep) begin
      elapsed_units_next = '0;
      current_level_next = '0;
      duty               = '0;
    end

    word_next = {2'b00, sleep, evt.ev, current_level_next,
                 (current_level_next != '0), duty};
  end

  // level state
  always_ff @(posedge clk) begin
    if (rst) begin
      current_level   <= '0;
      ramp_duty       <= RAMP_DUTY_RST;
      unit_tick_count <= '0;
      elapsed_units   <= '0;
    end else if (pop) begin
      current_level   <= current_level_next;
      ramp_duty       <= ramp_duty_next;
      unit_tick_count <= unit_tick_count_next;
      elapsed_units   <= elapsed_units_next;
    end
  end

  // output word register
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (pop) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      m_tdata <= word_next;
    end
  end

endmodule

`default_nettype wire

/* hdl/button_level_pwm_controller.sv */
// top level: settings, press qualifier, event queue and level logic
`timescale 1ns / 1ps
`default_nettype none

// Each input word is one 10 ms tick carrying the button level; each tick gives
// exactly one output word with the pwm duty, enable, level, press event and
// sleep request. The block takes one word per clock cycle while the queue is
// not full: the press qualifier classifies the tick on acceptance, a two-entry
// queue holds the event, and the level logic updates once per word into the
// output register; a word passes the queue, then the output register, to the
// master side. The queue and the output register let either side stall without
// losing or repeating words. The user must write settings via cfg_we/cfg_index/
// cfg_data only while no tick is in flight; the block does not enforce it.
module button_level_pwm_controller
  import blpc_pkg::*;
#(
  parameter int unsigned NUM_LEVELS = NUM_LEVELS_DEF
) (
  input  wire logic                   clk,
  input  wire logic                   rst,
  input  wire logic                   s_tvalid,
  output logic                        s_tready,
  input  wire logic [IN_TDATA_W-1:0]  s_tdata,   // [0] key_pressed, rest zero
  output logic                        m_tvalid,
  input  wire logic                   m_tready,
  // [6:0] pwm_duty, [7] pwm_enable, [10:8] level, [12:11] press_event,
  // [13] sleep_request, rest zero
  output logic [OUT_TDATA_W-1:0]      m_tdata,
  input  wire logic                   cfg_we,
  input  wire logic [CFG_IDX_W-1:0]   cfg_index,
  input  wire logic [CFG_DATA_W-1:0]  cfg_data
);

  logic [COUNT_W-1:0] debounce_ticks, long_press_ticks;
  back_cfg_t          bcfg;
  logic               q_full, q_avail, q_pop, tick;
  tick_evt_t          front_evt, queue_evt;

  // settings registers
  always_ff @(posedge clk) begin
    if (rst) begin
      debounce_ticks      <= 8'd5;
      long_press_ticks    <= 8'd200;
      bcfg.ticks_per_unit <= 7'd99;
      bcfg.timeout_units  <= 10'd900;
      bcfg.ramp_floor     <= 7'd77;
      bcfg.ramp_start     <= 7'd90;
      bcfg.ramp_step      <= 4'd2;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_DEBOUNCE:   debounce_ticks      <= cfg_data[COUNT_W-1:0];
        CFG_LONG_PRESS: long_press_ticks    <= cfg_data[COUNT_W-1:0];
        CFG_TICKS_UNIT: bcfg.ticks_per_unit <= cfg_data[UNIT_W-1:0];
        CFG_TIMEOUT:    bcfg.timeout_units  <= cfg_data[ELAP_W-1:0];
        CFG_RAMP_FLOOR: bcfg.ramp_floor     <= cfg_data[DUTY_W-1:0];
        CFG_RAMP_START: bcfg.ramp_start     <= cfg_data[DUTY_W-1:0];
        CFG_RAMP_STEP:  bcfg.ramp_step      <= cfg_data[3:0];
        default: ;
      endcase
    end
  end

  assign s_tready = !q_full;
  assign tick     = s_tvalid && s_tready;

  // front: press qualifier
  blpc_front u_front (
    .clk              (clk),
    .rst              (rst),
    .tick             (tick),
    .key_pressed      (s_tdata[0]),
    .debounce_ticks   (debounce_ticks),
    .long_press_ticks (long_press_ticks),
    .evt              (front_evt)
  );

  // event queue
  blpc_queue u_queue (
    .clk      (clk),
    .rst      (rst),
    .push     (tick),
    .push_evt (front_evt),
    .full     (q_full),
    .pop      (q_pop),
    .avail    (q_avail),
    .pop_evt  (queue_evt)
  );

  // back: level, ramp and timeout
  blpc_back #(
    .NUM_LEVELS (NUM_LEVELS)
  ) u_back (
    .clk      (clk),
    .rst      (rst),
    .cfg      (bcfg),
    .avail    (q_avail),
    .evt      (queue_evt),
    .pop      (q_pop),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
  );

endmodule

`default_nettype wire

/* bench/button_level_pwm_controller_tb.sv */
// self-checking bench for the button level pwm controller: directed table, then random phases
`timescale 1ns / 1ps

module button_level_pwm_controller_tb;
  import blpc_pkg::*;

  localparam int HOLD_CYCLES = 60;
  localparam int NUM_PHASES  = 16;
  localparam int PHASE_TICKS = 25;

  // one output word split into its fields
  typedef struct packed {
    logic [DUTY_W-1:0]  duty;
    logic               enable;
    logic [LEVEL_W-1:0] level;
    press_event_t       ev;
    logic               sleep;
  } pwm_word_t;

  typedef enum logic {ROW_TICK, ROW_REG} row_kind_t;

  // one line of the directed table
  typedef struct packed {
    row_kind_t             kind;
    logic                  key;
    cfg_index_t            idx;
    logic [CFG_DATA_W-1:0] data;
    logic                  fixed;
    pwm_word_t             word;
  } dir_row_t;

  logic                   clk = 1'b0;
  logic                   rst = 1'b1;
  logic                   s_tvalid = 1'b0;
  logic                   s_tready;
  logic [IN_TDATA_W-1:0]  s_tdata = '0;
  logic                   m_tvalid;
  logic                   m_tready = 1'b0;
  logic [OUT_TDATA_W-1:0] m_tdata;
  logic                   cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0]   cfg_index = '0;
  logic [CFG_DATA_W-1:0]  cfg_data = '0;

  button_level_pwm_controller dut (
    .clk       (clk),
    .rst       (rst),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  // settings as the block should hold them
  logic [COUNT_W-1:0] debounce_set;
  logic [COUNT_W-1:0] long_set;
  logic [UNIT_W-1:0]  ticks_per_unit_set;
  logic [ELAP_W-1:0]  timeout_set;
  logic [DUTY_W-1:0]  ramp_floor_set;
  logic [DUTY_W-1:0]  ramp_start_set;
  logic [3:0]         ramp_step_set;

  // controller state as it should evolve
  logic [COUNT_W-1:0] held_ticks;
  logic               long_latched;
  logic [LEVEL_W-1:0] cur_level;
  logic [DUTY_W-1:0]  ramp_now;
  logic [UNIT_W-1:0]  unit_ticks;
  logic [ELAP_W-1:0]  units_elapsed;

  pwm_word_t pending_words [$];
  int        errors = 0;
  int        sender_idle_pct = 0;
  int        recv_stall_pct = 0;
  int        hold_kick = 0;
  int        hold_left = 0;
  int        phase_ticks = 0;

  // clock
  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // run limit
  initial begin
    #10_000_000;
    $display("Regression FAIL");
    $finish;
  end

  // expected word for one tick, advancing the state
  function automatic pwm_word_t next_pwm_word(input logic key);
    pwm_word_t          w;
    int                 n;
    logic               slp;
    logic [DUTY_W-1:0]  duty;
    press_event_t       ev;
    // timeout units only count while a level is on
    if (cur_level != '0) begin
      n = int'(unit_ticks) + 1;
      if (n >= int'(ticks_per_unit_set)) begin
        unit_ticks = '0;
        if (units_elapsed < ELAP_MAX) units_elapsed = units_elapsed + 1'b1;
      end else begin
        unit_ticks = n[UNIT_W-1:0];
      end
    end
    // press qualifier, counter saturates at the long limit
    ev = EV_NONE;
    if (key) begin
      n = int'(held_ticks) + 1;
      if (n >= int'(long_set)) begin
        held_ticks = long_set;
        if (!long_latched) begin
          long_latched = 1'b1;
          ev = EV_LONG;
        end
      end else begin
        held_ticks = n[COUNT_W-1:0];
      end
    end else begin
      if (held_ticks >= long_set) long_latched = 1'b0;
      else if (held_ticks >= debounce_set) ev = EV_SHORT;
      held_ticks = '0;
    end
    // level step, wrap clears the elapsed units
    if (ev == EV_SHORT) begin
      if (int'(cur_level) + 1 >= int'(NUM_LEVELS_DEF)) begin
        cur_level = '0;
        units_elapsed = '0;
      end else begin
        cur_level = cur_level + 1'b1;
      end
      if (cur_level == 3'd1) ramp_now = ramp_start_set;
    end else if (ev == EV_LONG) begin
      cur_level = '0;
    end
    // duty per level, level one ramps down and may dip below the floor once
    slp = 1'b0;
    duty = '0;
    if (cur_level == '0) begin
      slp = (held_ticks == '0);
    end else if (cur_level == 3'd1) begin
      if (ramp_now > ramp_floor_set) begin
        ramp_now = (ramp_now >= ramp_step_set) ? ramp_now - ramp_step_set : '0;
        duty = ramp_now;
      end else begin
        duty = ramp_floor_set;
      end
    end else begin
      case (cur_level)
        3'd2:    duty = 7'd81;
        3'd3:    duty = 7'd85;
        3'd4:    duty = 7'd90;
        3'd5:    duty = 7'd93;
        default: duty = 7'd97;
      endcase
    end
    if (units_elapsed >= timeout_set) slp = 1'b1;
    // sleep forces everything off
    if (slp) begin
      units_elapsed = '0;
      cur_level = '0;
      duty = '0;
    end
    w.duty = duty;
    w.enable = (cur_level != '0);
    w.level = cur_level;
    w.ev = ev;
    w.sleep = slp;
    return w;
  endfunction

  // directed table row builders
  function automatic dir_row_t tick_row(input logic key);
    dir_row_t r;
    r = '0;
    r.kind = ROW_TICK;
    r.key = key;
    return r;
  endfunction

  function automatic dir_row_t reg_row(input cfg_index_t idx, input int data);
    dir_row_t r;
    r = '0;
    r.kind = ROW_REG;
    r.idx = idx;
    r.data = data[CFG_DATA_W-1:0];
    return r;
  endfunction

  function automatic dir_row_t fixed_row(input logic key, input int duty, input logic en,
                                         input int lvl, input press_event_t ev,
                                         input logic slp);
    dir_row_t r;
    r = tick_row(key);
    r.fixed = 1'b1;
    r.word.duty = duty[DUTY_W-1:0];
    r.word.enable = en;
    r.word.level = lvl[LEVEL_W-1:0];
    r.word.ev = ev;
    r.word.sleep = slp;
    return r;
  endfunction

  // receiver: random stalls plus one long hold-off
  always @(posedge clk) begin
    if (hold_kick != 0) begin
      hold_kick = 0;
      hold_left = HOLD_CYCLES;
    end
    if (hold_left > 0) begin
      hold_left = hold_left - 1;
      m_tready <= 1'b0;
    end else begin
      m_tready <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  // output checker
  always @(posedge clk) begin : word_check
    pwm_word_t want;
    if (!rst && m_tvalid && m_tready) begin
      if (pending_words.size() == 0) begin
        $error("output word 0x%h with no word pending", m_tdata);
        errors++;
      end else begin
        want = pending_words.pop_front();
        if (m_tdata[6:0] !== want.duty) begin
          $error("pwm_duty: expected %0d, got %0d", want.duty, m_tdata[6:0]);
          errors++;
        end
        if (m_tdata[7] !== want.enable) begin
          $error("pwm_enable: expected %0d, got %0d", want.enable, m_tdata[7]);
          errors++;
        end
        if (m_tdata[10:8] !== want.level) begin
          $error("level: expected %0d, got %0d", want.level, m_tdata[10:8]);
          errors++;
        end
        if (m_tdata[12:11] !== want.ev) begin
          $error("press_event: expected %0d, got %0d", want.ev, m_tdata[12:11]);
          errors++;
        end
        if (m_tdata[13] !== want.sleep) begin
          $error("sleep_request: expected %0d, got %0d", want.sleep, m_tdata[13]);
          errors++;
        end
        if (m_tdata[15:14] !== 2'b00) begin
          $error("padding: expected 0, got %0d", m_tdata[15:14]);
          errors++;
        end
      end
    end
  end

  // offer one tick, with random idle cycles ahead of it
  task automatic send_tick(input logic key, input logic fixed, input pwm_word_t fixed_word);
    pwm_word_t w;
    while ($urandom_range(99) < sender_idle_pct) begin
      s_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata <= {{(IN_TDATA_W-1){1'b0}}, key};
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    w = next_pwm_word(key);
    pending_words.push_back(fixed ? fixed_word : w);
    phase_ticks++;
  endtask

  // stop offering and wait for every pending word
  task automatic wait_drained(input int extra);
    s_tvalid <= 1'b0;
    while (pending_words.size() != 0) @(posedge clk);
    repeat (extra) @(posedge clk);
  endtask

  // register write, block must be idle
  task automatic write_reg(input cfg_index_t idx, input int data);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= data[CFG_DATA_W-1:0];
    @(posedge clk);
    cfg_we <= 1'b0;
    @(posedge clk);
    case (idx)
      CFG_DEBOUNCE:   debounce_set = data[COUNT_W-1:0];
      CFG_LONG_PRESS: long_set = data[COUNT_W-1:0];
      CFG_TICKS_UNIT: ticks_per_unit_set = data[UNIT_W-1:0];
      CFG_TIMEOUT:    timeout_set = data[ELAP_W-1:0];
      CFG_RAMP_FLOOR: ramp_floor_set = data[DUTY_W-1:0];
      CFG_RAMP_START: ramp_start_set = data[DUTY_W-1:0];
      CFG_RAMP_STEP:  ramp_step_set = data[3:0];
      default: ;
    endcase
  endtask

  task automatic write_all(input int deb, input int lng, input int tpu, input int tmo,
                           input int flr, input int strt, input int stp);
    write_reg(CFG_DEBOUNCE, deb);
    write_reg(CFG_LONG_PRESS, lng);
    write_reg(CFG_TICKS_UNIT, tpu);
    write_reg(CFG_TIMEOUT, tmo);
    write_reg(CFG_RAMP_FLOOR, flr);
    write_reg(CFG_RAMP_START, strt);
    write_reg(CFG_RAMP_STEP, stp);
  endtask

  // one button gesture: mostly press and release, sometimes noise
  task automatic send_gesture();
    int kind;
    int len;
    int span;
    int i;
    kind = $urandom_range(9);
    if (kind == 9) begin
      len = $urandom_range(1, 6);
      for (i = 0; i < len; i++) send_tick(1'($urandom_range(1)), 1'b0, '0);
    end else begin
      if (kind <= 5) begin
        span = (int'(long_set) > int'(debounce_set) + 1) ?
               int'(long_set) - int'(debounce_set) - 1 : 0;
        len = int'(debounce_set) + $urandom_range(span);
      end else if (kind <= 7) begin
        len = int'(long_set) + $urandom_range(3);
      end else begin
        len = $urandom_range(1, (debounce_set > 1) ? int'(debounce_set) - 1 : 1);
      end
      if (len < 1) len = 1;
      for (i = 0; i < len; i++) send_tick(1'b1, 1'b0, '0);
      len = $urandom_range(1, 3);
      for (i = 0; i < len; i++) send_tick(1'b0, 1'b0, '0);
    end
  endtask

  // main sequence
  initial begin : stimulus
    dir_row_t dir_rows [0:32];
    int       i;
    int       ph;
    int       target;
    logic     paused;

    // reset state and settings
    debounce_set = 8'd5;
    long_set = 8'd200;
    ticks_per_unit_set = 7'd99;
    timeout_set = 10'd900;
    ramp_floor_set = 7'd77;
    ramp_start_set = 7'd90;
    ramp_step_set = 4'd2;
    held_ticks = '0;
    long_latched = 1'b0;
    cur_level = '0;
    ramp_now = RAMP_DUTY_RST;
    unit_ticks = '0;
    units_elapsed = '0;

    dir_rows = '{
      // idle after reset asks for sleep; one held tick defers it
      fixed_row(1'b0, 0, 1'b0, 0, EV_NONE, 1'b1),
      fixed_row(1'b1, 0, 1'b0, 0, EV_NONE, 1'b0),
      reg_row(CFG_DEBOUNCE, 2),
      reg_row(CFG_LONG_PRESS, 4),
      reg_row(CFG_TICKS_UNIT, 1),
      reg_row(CFG_TIMEOUT, 1023),
      reg_row(CFG_RAMP_FLOOR, 77),
      reg_row(CFG_RAMP_START, 80),
      reg_row(CFG_RAMP_STEP, 2),
      // short press into level one, ramp dips below the floor once then holds
      tick_row(1'b1), tick_row(1'b0), tick_row(1'b0), tick_row(1'b0),
      // bounce shorter than the debounce count
      tick_row(1'b1), tick_row(1'b0),
      // short press to level two
      tick_row(1'b1), tick_row(1'b1), tick_row(1'b0),
      // long hold turns off, held past the limit, release sleeps
      tick_row(1'b1), tick_row(1'b1), tick_row(1'b1), tick_row(1'b1),
      tick_row(1'b1), tick_row(1'b0),
      // ramp step larger than the duty saturates at zero
      reg_row(CFG_RAMP_START, 3),
      reg_row(CFG_RAMP_STEP, 15),
      reg_row(CFG_RAMP_FLOOR, 0),
      tick_row(1'b1), tick_row(1'b1),
      fixed_row(1'b0, 0, 1'b1, 1, EV_SHORT, 1'b0),
      // runtime timeout forces off and sleep
      reg_row(CFG_TIMEOUT, 2),
      tick_row(1'b0),
      fixed_row(1'b0, 0, 1'b0, 0, EV_NONE, 1'b1)
    };

    repeat (11) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // directed table
    for (i = 0; i < 33; i++) begin
      if (dir_rows[i].kind == ROW_REG) begin
        wait_drained(4);
        write_reg(dir_rows[i].idx, int'(dir_rows[i].data));
      end else begin
        send_tick(dir_rows[i].key, dir_rows[i].fixed, dir_rows[i].word);
      end
    end

    // random phases, each with its own settings and idling pattern
    for (ph = 0; ph < NUM_PHASES; ph++) begin
      wait_drained(4);
      case (ph)
        0: write_all(255, 255, 127, 1023, 100, 100, 15);
        1: write_all(1, 2, 1, 1, 0, 0, 1);
        2: write_all(0, 1, 0, 5, 127, 127, 0);
        3: write_all(3, 0, 2, 20, 77, 90, 2);
        default: write_all($urandom_range(1, 8), $urandom_range(2, 24), $urandom_range(1, 6),
                           $urandom_range(1, 40), $urandom_range(0, 100),
                           $urandom_range(0, 127), $urandom_range(1, 15));
      endcase
      case (ph % 4)
        0: begin sender_idle_pct = 0;  recv_stall_pct = 0;  end
        1: begin sender_idle_pct = 53; recv_stall_pct = 0;  end
        2: begin sender_idle_pct = 0;  recv_stall_pct = 53; end
        default: begin sender_idle_pct = 34; recv_stall_pct = 34; end
      endcase
      // long receiver hold-off while the sender keeps offering
      if (ph == 4) hold_kick = 1;
      target = (ph == 0) ? 100 : PHASE_TICKS;
      phase_ticks = 0;
      paused = 1'b0;
      while (phase_ticks < target) begin
        // sender pause until everything is out
        if (ph == 5 && !paused && phase_ticks >= target / 2) begin
          paused = 1'b1;
          wait_drained(1);
        end
        send_gesture();
      end
    end

    wait_drained(10);
    if (errors == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule

/* files.f */
hdl/blpc_pkg.sv
hdl/blpc_front.sv
hdl/blpc_queue.sv
hdl/blpc_back.sv
hdl/button_level_pwm_controller.sv
bench/button_level_pwm_controller_tb.sv
